>>> design/sfd_pkg.sv
package sfd_pkg;

  localparam int FRAME_LEN = 25;

  typedef logic [4:0] pos_t;

  localparam pos_t FLAGS_POS  = 5'd23;
  localparam pos_t LAST_POS   = 5'd24;
  localparam pos_t FIRST_CHAN = 5'd1;
  localparam pos_t NUM_ANALOG = 5'd16;
  localparam pos_t DIG_LAST   = 5'd17;

  localparam logic [7:0]  START_RESET   = 8'd15;
  localparam logic [7:0]  END_RESET     = 8'd0;
  localparam logic [9:0]  TIMEOUT_RESET = 10'd100;
  localparam logic [9:0]  QUIET_MAX     = 10'd1023;
  localparam logic [10:0] DIGITAL_ON    = 11'd2047;

  localparam int DIG0_BIT     = 0;
  localparam int DIG1_BIT     = 1;
  localparam int LOST_BIT     = 2;
  localparam int FAILSAFE_BIT = 3;

  localparam logic [1:0] CFG_START   = 2'd0;
  localparam logic [1:0] CFG_END     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic MODE_BYTE   = 1'b0;
  localparam logic MODE_TICK   = 1'b1;
  localparam logic KIND_CHAN   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLAG_RD,
    ST_FLAG_LD,
    ST_UN_RD,
    ST_UN_LD,
    ST_UN_EM,
    ST_DIG,
    ST_STAT
  } st_t;

  // position in the ring of frame bytes
  function automatic pos_t ring_pos(pos_t base, pos_t off);
    logic [5:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= 6'(FRAME_LEN)) begin
      s = s - 6'(FRAME_LEN);
    end
    return s[4:0];
  endfunction

endpackage

>>> design/sfd_in_if.sv
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

>>> design/sfd_out_if.sv
interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [4:0]  channel_index;
  logic [10:0] channel_value;
  logic        frame_lost;
  logic        failsafe;
  logic        last;

  modport source (output valid, output kind, output channel_index, output channel_value,
                  output frame_lost, output failsafe, output last, input ready);
  modport sink (input valid, input kind, input channel_index, input channel_value,
                input frame_lost, input failsafe, input last, output ready);
endinterface

>>> design/sfd_ram.sv
module sfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 25,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/sbus_frame_decoder_core.sv
// channel  dir  payload                                                   word
// in_if    in   mode, data_byte                                           byte or 1 ms tick
// out_if   out  kind, channel_index, channel_value, frame_lost, failsafe, last   result
// cfg_*    in   cfg_index selects start_byte / end_byte / timeout_ms      register write
//
// A tick that times out also emits a status word. A byte closing a frame with a bad end
// byte starts a rescan with one RAM read per scanned byte. A good frame is paced by the
// single RAM read port: the flags read, then a read, load and emit step per byte of the 22
// unpacked, and one per output word.
// Output stalls hold the sequencer; in_if is ready only between items.
// Reset is synchronous; the frame RAM is not cleared.
module sbus_frame_decoder_core
  import sfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sfd_in_if.sink     in_if,
  sfd_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  st_t state_r, state_nxt;

  logic [7:0]  start_r, end_r;
  logic [9:0]  timeout_r;
  pos_t        base_r, base_nxt;
  pos_t        fill_r, fill_nxt;
  logic [9:0]  quiet_r, quiet_nxt;
  logic        fs_r, fs_nxt;
  logic        lost_r, lost_nxt;
  pos_t        scan_r, scan_nxt;
  pos_t        rd_tag_r, rd_tag_nxt;
  logic        rd_vld_r, rd_vld_nxt;
  pos_t        ptr_r, ptr_nxt;
  pos_t        ch_r, ch_nxt;
  logic [17:0] acc_r, acc_nxt;
  logic [4:0]  nbits_r, nbits_nxt;
  logic [7:0]  flags_r, flags_nxt;

  logic        ov_r, ov_nxt;
  logic        okind_r, okind_nxt;
  pos_t        oidx_r, oidx_nxt;
  logic [10:0] oval_r, oval_nxt;
  logic        olost_r, olost_nxt;
  logic        ofs_r, ofs_nxt;
  logic        olast_r, olast_nxt;

  logic        ram_we;
  pos_t        ram_off, ring_addr;
  logic [7:0]  ram_rdata;

  logic        tick_acc, byte_acc, byte_keep, end_ok, frame_full, tick_fire;
  logic        out_free, hit, scan_end;
  logic [9:0]  quiet_inc;

  sfd_ram #(.Width(8), .Depth(FRAME_LEN)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ring_addr),
    .wdata (in_if.data_byte),
    .raddr (ring_addr),
    .rdata (ram_rdata)
  );

  assign in_if.ready = (state_r == ST_IDLE);
  assign out_free    = !ov_r || out_if.ready;

  assign tick_acc   = in_if.valid && in_if.ready && (in_if.mode == MODE_TICK);
  assign byte_acc   = in_if.valid && in_if.ready && (in_if.mode == MODE_BYTE);
  assign byte_keep  = (fill_r != '0) || (in_if.data_byte == start_r);
  assign frame_full = (fill_r == LAST_POS);
  assign end_ok     = (in_if.data_byte == end_r);
  assign quiet_inc  = (quiet_r == QUIET_MAX) ? quiet_r : quiet_r + 10'd1;
  assign tick_fire  = tick_acc && (quiet_inc > timeout_r);
  assign hit        = rd_vld_r && (ram_rdata == start_r);
  assign scan_end   = rd_vld_r && (rd_tag_r == LAST_POS);

  // shared ring address unit
  always_comb begin
    unique case (state_r)
      ST_IDLE:    ram_off = fill_r;
      ST_SCAN:    ram_off = scan_r;
      ST_FLAG_RD: ram_off = FLAGS_POS;
      default:    ram_off = ptr_r;
    endcase
  end
  assign ring_addr = ring_pos(base_r, ram_off);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tick_fire) begin
          state_nxt = ST_STAT;
        end else if (byte_acc && byte_keep && frame_full) begin
          state_nxt = end_ok ? ST_FLAG_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || scan_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLAG_RD: state_nxt = ST_FLAG_LD;
      ST_FLAG_LD: state_nxt = ST_UN_RD;
      ST_UN_RD:   state_nxt = ST_UN_LD;
      ST_UN_LD:   state_nxt = ST_UN_EM;
      ST_UN_EM: begin
        if (nbits_r < 5'd11) begin
          state_nxt = (ch_r == NUM_ANALOG) ? ST_DIG : ST_UN_RD;
        end
      end
      ST_DIG: begin
        if (out_free && ch_r == DIG_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_STAT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    base_nxt   = base_r;
    fill_nxt   = fill_r;
    quiet_nxt  = quiet_r;
    fs_nxt     = fs_r;
    lost_nxt   = lost_r;
    scan_nxt   = scan_r;
    rd_tag_nxt = rd_tag_r;
    rd_vld_nxt = rd_vld_r;
    ptr_nxt    = ptr_r;
    ch_nxt     = ch_r;
    acc_nxt    = acc_r;
    nbits_nxt  = nbits_r;
    flags_nxt  = flags_r;
    ov_nxt     = ov_r && !out_if.ready;
    okind_nxt  = okind_r;
    oidx_nxt   = oidx_r;
    oval_nxt   = oval_r;
    olost_nxt  = olost_r;
    ofs_nxt    = ofs_r;
    olast_nxt  = olast_r;
    ram_we     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        rd_vld_nxt = 1'b0;
        if (tick_acc) begin
          quiet_nxt = quiet_inc;
          if (tick_fire) begin
            fs_nxt = 1'b1;
          end
        end else if (byte_acc && byte_keep) begin
          ram_we = 1'b1;
          if (!frame_full) begin
            fill_nxt = fill_r + 5'd1;
          end else if (end_ok) begin
            fill_nxt = '0;
          end else begin
            scan_nxt = FIRST_CHAN;
          end
        end
      end
      ST_SCAN: begin
        rd_tag_nxt = scan_r;
        rd_vld_nxt = (scan_r <= LAST_POS);
        scan_nxt   = scan_r + 5'd1;
        if (hit) begin
          base_nxt = ring_pos(base_r, rd_tag_r);
          fill_nxt = 5'(FRAME_LEN) - rd_tag_r;
        end else if (scan_end) begin
          fill_nxt = '0;
        end
      end
      ST_FLAG_RD: ;
      ST_FLAG_LD: begin
        flags_nxt = ram_rdata;
        lost_nxt  = ram_rdata[LOST_BIT];
        fs_nxt    = ram_rdata[FAILSAFE_BIT];
        quiet_nxt = '0;
        ptr_nxt   = FIRST_CHAN;
        acc_nxt   = '0;
        nbits_nxt = '0;
        ch_nxt    = '0;
      end
      ST_UN_RD: ;
      ST_UN_LD: begin
        acc_nxt   = acc_r | ({10'd0, ram_rdata} << nbits_r);
        nbits_nxt = nbits_r + 5'd8;
        ptr_nxt   = ptr_r + 5'd1;
      end
      ST_UN_EM: begin
        if (nbits_r >= 5'd11 && out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_CHAN;
          oidx_nxt  = ch_r;
          oval_nxt  = acc_r[10:0];
          olost_nxt = lost_r;
          ofs_nxt   = fs_r;
          olast_nxt = 1'b0;
          acc_nxt   = acc_r >> 11;
          nbits_nxt = nbits_r - 5'd11;
          ch_nxt    = ch_r + 5'd1;
        end
      end
      ST_DIG: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_CHAN;
          oidx_nxt  = ch_r;
          if (ch_r == NUM_ANALOG) begin
            oval_nxt = flags_r[DIG0_BIT] ? DIGITAL_ON : '0;
          end else begin
            oval_nxt = flags_r[DIG1_BIT] ? DIGITAL_ON : '0;
          end
          olost_nxt = lost_r;
          ofs_nxt   = fs_r;
          olast_nxt = (ch_r == DIG_LAST);
          ch_nxt    = ch_r + 5'd1;
        end
      end
      ST_STAT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_STATUS;
          oidx_nxt  = '0;
          oval_nxt  = '0;
          olost_nxt = lost_r;
          ofs_nxt   = 1'b1;
          olast_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      start_r   <= START_RESET;
      end_r     <= END_RESET;
      timeout_r <= TIMEOUT_RESET;
      base_r    <= '0;
      fill_r    <= '0;
      quiet_r   <= '0;
      fs_r      <= 1'b0;
      lost_r    <= 1'b0;
      rd_vld_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      base_r   <= base_nxt;
      fill_r   <= fill_nxt;
      quiet_r  <= quiet_nxt;
      fs_r     <= fs_nxt;
      lost_r   <= lost_nxt;
      rd_vld_r <= rd_vld_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START:   start_r   <= cfg_data[7:0];
          CFG_END:     end_r     <= cfg_data[7:0];
          CFG_TIMEOUT: timeout_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r   <= scan_nxt;
    rd_tag_r <= rd_tag_nxt;
    ptr_r    <= ptr_nxt;
    ch_r     <= ch_nxt;
    acc_r    <= acc_nxt;
    nbits_r  <= nbits_nxt;
    flags_r  <= flags_nxt;
    okind_r  <= okind_nxt;
    oidx_r   <= oidx_nxt;
    oval_r   <= oval_nxt;
    olost_r  <= olost_nxt;
    ofs_r    <= ofs_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_if.valid         = ov_r;
  assign out_if.kind          = okind_r;
  assign out_if.channel_index = oidx_r;
  assign out_if.channel_value = oval_r;
  assign out_if.frame_lost    = olost_r;
  assign out_if.failsafe      = ofs_r;
  assign out_if.last          = olast_r;

  a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (base_r <= LAST_POS) && (fill_r <= LAST_POS))
    else $error("frame ring pointer out of range");

  a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind == KIND_STATUS) |->
      (out_if.failsafe && out_if.last && out_if.channel_index == '0))
    else $error("malformed status word");

  a_digital_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind == KIND_CHAN && out_if.channel_index >= NUM_ANALOG) |->
      (out_if.channel_value == '0 || out_if.channel_value == DIGITAL_ON))
    else $error("digital channel value not 0 or full scale");

  a_stat_failsafe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STAT) |-> fs_r)
    else $error("status pending without failsafe set");

endmodule

>>> tb/sbus_frame_decoder_core_tb.sv
module sbus_frame_decoder_core_tb
  import sfd_pkg::*;
();

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 12;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam int FILL_RAND  = 0;
  localparam int FILL_ONES  = 1;
  localparam int FILL_ZEROS = 2;
  localparam int FILL_AVOID = 3;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
  } serial_word_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  idx;
    logic [10:0] value;
    logic        lost;
    logic        fs;
    logic        last_w;
  } chan_word_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [9:0] cfg_data;

  sfd_in_if  in_ch();
  sfd_out_if out_ch();

  sbus_frame_decoder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // decoder mirror
  logic [7:0] start_val;
  logic [7:0] end_val;
  logic [9:0] timeout_val;
  logic [7:0] frame_buf [FRAME_LEN];
  int         fill_n;
  logic [9:0] quiet_ms;
  logic       fs_flag;
  logic       lost_flag;

  serial_word_t serial_q[$];
  chan_word_t   decoded_q[$];

  int   send_idle_pct;
  int   recv_stall_pct;
  logic rx_hold;

  int n_queued   = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_good     = 0;
  int n_resync   = 0;
  int n_status   = 0;
  int cycle_n    = 0;

  function automatic chan_word_t make_word(logic kind, logic [4:0] idx, logic [10:0] value,
                                           logic last_w);
    chan_word_t w;
    w.kind   = kind;
    w.idx    = idx;
    w.value  = value;
    w.lost   = lost_flag;
    w.fs     = fs_flag;
    w.last_w = last_w;
    return w;
  endfunction

  function automatic logic [10:0] analog_value(int k);
    int          bitpos;
    logic [23:0] w;
    bitpos = 11 * k;
    w = {frame_buf[bitpos / 8 + 3], frame_buf[bitpos / 8 + 2], frame_buf[bitpos / 8 + 1]};
    return 11'(w >> (bitpos % 8));
  endfunction

  function automatic void realign();
    int i;
    int j;
    for (i = 1; i < FRAME_LEN; i++) begin
      if (frame_buf[i] == start_val) begin
        for (j = 0; j + i < FRAME_LEN; j++) frame_buf[j] = frame_buf[j + i];
        fill_n = FRAME_LEN - i;
        return;
      end
    end
    fill_n = 0;
  endfunction

  function automatic void sbus_decode(serial_word_t w);
    logic [7:0] flg;
    int         k;
    if (w.mode == MODE_TICK) begin
      if (quiet_ms != QUIET_MAX) quiet_ms++;
      if (quiet_ms > timeout_val) begin
        fs_flag = 1'b1;
        decoded_q.push_back(make_word(KIND_STATUS, 5'd0, 11'd0, 1'b1));
        n_status++;
      end
      return;
    end
    if (fill_n == 0 && w.data != start_val) return;
    frame_buf[fill_n] = w.data;
    fill_n++;
    if (fill_n < FRAME_LEN) return;
    if (frame_buf[LAST_POS] != end_val) begin
      realign();
      n_resync++;
      return;
    end
    fill_n    = 0;
    quiet_ms  = '0;
    flg       = frame_buf[FLAGS_POS];
    lost_flag = flg[LOST_BIT];
    fs_flag   = flg[FAILSAFE_BIT];
    for (k = 0; k < NUM_ANALOG; k++) begin
      decoded_q.push_back(make_word(KIND_CHAN, 5'(k), analog_value(k), 1'b0));
    end
    decoded_q.push_back(make_word(KIND_CHAN, NUM_ANALOG,
                                  flg[DIG0_BIT] ? DIGITAL_ON : 11'd0, 1'b0));
    decoded_q.push_back(make_word(KIND_CHAN, DIG_LAST,
                                  flg[DIG1_BIT] ? DIGITAL_ON : 11'd0, 1'b1));
    n_good++;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : cycle_watch
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d words outstanding", decoded_q.size());
      $display("sbus_frame_decoder_core_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin : byte_drive
    serial_word_t acc;
    serial_word_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        acc.mode = in_ch.mode;
        acc.data = in_ch.data_byte;
        sbus_decode(acc);
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (serial_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = serial_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.mode      <= nxt.mode;
          in_ch.data_byte <= nxt.data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : chan_check
    chan_word_t got;
    chan_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind   = out_ch.kind;
        got.idx    = out_ch.channel_index;
        got.value  = out_ch.channel_value;
        got.lost   = out_ch.frame_lost;
        got.fs     = out_ch.failsafe;
        got.last_w = out_ch.last;
        n_checked++;
        if (decoded_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("ERROR @%0d: unexpected word kind %0d ch %0d value %0d lost %0d fs %0d last %0d",
                     cycle_n, got.kind, got.idx, got.value, got.lost, got.fs, got.last_w);
          end
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("ERROR @%0d: expected kind %0d ch %0d value %0d lost %0d fs %0d last %0d",
                       cycle_n, want.kind, want.idx, want.value, want.lost, want.fs,
                       want.last_w);
              $display("              got kind %0d ch %0d value %0d lost %0d fs %0d last %0d",
                       got.kind, got.idx, got.value, got.lost, got.fs, got.last_w);
            end
          end
        end
      end
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_word(input logic mode, input logic [7:0] data);
    serial_word_t w;
    w.mode = mode;
    w.data = data;
    serial_q.push_back(w);
    n_queued++;
  endtask

  // line noise: never a start byte, not counted as traffic
  task automatic push_noise(input int n);
    serial_word_t w;
    repeat (n) begin
      w.mode = MODE_BYTE;
      w.data = 8'($urandom);
      while (w.data == start_val) w.data = 8'($urandom);
      serial_q.push_back(w);
    end
  endtask

  function automatic logic [7:0] body_byte(int fill);
    logic [7:0] b;
    case (fill)
      FILL_ONES:  b = 8'hFF;
      FILL_ZEROS: b = 8'h00;
      default: begin
        b = 8'($urandom);
        case ($urandom_range(7))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: ;
        endcase
        while (fill == FILL_AVOID && b == start_val) b = 8'($urandom);
      end
    endcase
    return b;
  endfunction

  task automatic push_frame(input logic [7:0] flags, input logic [7:0] tail,
                            input int n_starts, input int fill, input bit with_ticks);
    logic [7:0] img [FRAME_LEN];
    int         i;
    img[0] = start_val;
    for (i = 1; i < FLAGS_POS; i++) img[i] = body_byte(fill);
    repeat (n_starts) img[$urandom_range(FLAGS_POS - 1, 1)] = start_val;
    img[FLAGS_POS] = flags;
    img[LAST_POS]  = tail;
    for (i = 0; i < FRAME_LEN; i++) begin
      if (with_ticks && $urandom_range(15) == 0) push_word(MODE_TICK, 8'($urandom));
      push_word(MODE_BYTE, img[i]);
    end
  endtask

  task automatic random_traffic(input int n_items);
    int         stop_at;
    int         pick;
    int         n;
    logic [7:0] bad_tail;
    stop_at = n_queued + n_items;
    while (n_queued < stop_at) begin
      pick = $urandom_range(19);
      if (pick < 10) begin
        push_frame(8'($urandom), end_val, 0, FILL_RAND, $urandom_range(3) == 0);
      end else if (pick < 14) begin
        bad_tail = 8'($urandom);
        while (bad_tail == end_val) bad_tail = 8'($urandom);
        push_frame(8'($urandom), bad_tail, $urandom_range(2), FILL_RAND, 1'b0);
      end else if (pick < 16) begin
        n = (timeout_val > 25) ? $urandom_range(30, 1)
                               : $urandom_range(int'(timeout_val) + 3, 1);
        repeat (n) push_word(MODE_TICK, 8'($urandom));
      end else if (pick < 18) begin
        push_noise($urandom_range(4, 1));
      end else begin
        push_word(MODE_BYTE, start_val);
        n = $urandom_range(23, 1);
        repeat (n) push_word(MODE_BYTE, body_byte(FILL_RAND));
      end
    end
  endtask

  task automatic wait_idle();
    while (serial_q.size() != 0 || in_ch.valid || decoded_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [9:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_START:   start_val   = val[7:0];
      CFG_END:     end_val     = val[7:0];
      CFG_TIMEOUT: timeout_val = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] s, input logic [7:0] e, input logic [9:0] t);
    cfg_write(CFG_START, {2'b00, s});
    cfg_write(CFG_END, {2'b00, e});
    cfg_write(CFG_TIMEOUT, t);
  endtask

  initial begin : stimulus
    int ph;
    int i;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_START;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_BYTE;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    rx_hold         = 1'b0;
    send_idle_pct   = 9;
    recv_stall_pct  = 9;
    start_val       = START_RESET;
    end_val         = END_RESET;
    timeout_val     = TIMEOUT_RESET;
    fill_n          = 0;
    quiet_ms        = '0;
    fs_flag         = 1'b0;
    lost_flag       = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: extremes of the payload, both resync outcomes
    push_noise(1);
    push_frame(8'hFF, end_val, 0, FILL_ONES, 1'b0);
    push_frame(8'h00, end_val, 0, FILL_ZEROS, 1'b0);
    push_frame(8'h00, 8'hAA, 0, FILL_AVOID, 1'b0);
    push_frame(8'h0C, start_val, 0, FILL_AVOID, 1'b0);
    push_frame(8'h07, end_val, 2, FILL_AVOID, 1'b0);
    push_frame(8'h00, 8'hAA, 1, FILL_AVOID, 1'b0);
    wait_idle();

    // timeout extremes and an unused register index
    cfg_write(CFG_TIMEOUT, 10'd1000);
    push_word(MODE_TICK, 8'h00);
    wait_idle();
    cfg_write(CFG_TIMEOUT, 10'd0);
    cfg_write(CFG_UNUSED, 10'h3FF);
    push_word(MODE_TICK, 8'hFF);
    wait_idle();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_config(START_RESET, END_RESET, 10'd3);
        end
        1: begin
          send_idle_pct = 63; recv_stall_pct = 0;
          set_config(8'hFF, 8'h00, 10'd0);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 63;
          set_config(8'h00, 8'hFF, 10'd1);
        end
        default: begin
          send_idle_pct = 9;  recv_stall_pct = 9;
          set_config(8'($urandom), 8'($urandom), 10'($urandom_range(20, 2)));
        end
      endcase
      if (ph == 0) begin
        // output held off while words keep coming
        fork
          begin
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
        push_frame(8'($urandom), end_val, 0, FILL_RAND, 1'b0);
        for (i = 0; i < 4; i++) push_word(MODE_TICK, 8'($urandom));
        wait_idle();
      end
      random_traffic(PHASE_ITEMS);
      wait_idle();
    end

    n_errors += decoded_q.size();
    $display("%0d input words: %0d good frames, %0d realigned frames, %0d timeout words",
             n_accepted, n_good, n_resync, n_status);
    $display("%0d result words checked over four stall mixes, %0d errors", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("sbus_frame_decoder_core_tb OK");
    end else begin
      $display("sbus_frame_decoder_core_tb NOT OK");
    end
    $finish;
  end

endmodule
